FILE: src/ctt_pkg.sv
// Shared widths, opcodes and the result record of the change tick table.
package ctt_pkg;

  localparam int MAX_PROPS = 64;
  localparam int IDX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int TICK_W    = 32;
  localparam int OP_W      = 2;

  localparam logic [OP_W-1:0] OP_STAMP = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
  localparam logic [OP_W-1:0] OP_INIT  = 2'd2;

  typedef struct packed {
    logic [IDX_W-1:0] changed_index;
    logic             found;
    logic [CNT_W-1:0] match_count;
    logic             index_error;
    logic             last;
  } rsp_t;

endpackage

FILE: src/ctt_cfg_if.sv
// Configuration write channel carrying props_in_use.
interface ctt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ctt_pkg::CNT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: src/ctt_req_if.sv
// Request channel: opcode, property index and tick.
interface ctt_req_if;
  logic                             valid;
  logic                             ready;
  logic [ctt_pkg::OP_W-1:0]         opcode;
  logic [ctt_pkg::IDX_W-1:0]        prop_index;
  logic signed [ctt_pkg::TICK_W-1:0] tick;

  modport source (output valid, output opcode, output prop_index, output tick, input ready);
  modport sink   (input valid, input opcode, input prop_index, input tick, output ready);
endinterface

FILE: src/ctt_rsp_if.sv
// Result channel: one changed index or acknowledgement per transfer.
interface ctt_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [ctt_pkg::IDX_W-1:0] changed_index;
  logic                      found;
  logic [ctt_pkg::CNT_W-1:0] match_count;
  logic                      index_error;
  logic                      last;

  modport source (output valid, output changed_index, output found, output match_count,
                  output index_error, output last, input ready);
  modport sink   (input valid, input changed_index, input found, input match_count,
                  input index_error, input last, output ready);
endinterface

FILE: src/ctt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ctt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/change_tick_table_unit.sv
// Change tick table: stamp, init and changed-after-tick query over a tick RAM.
//
//   channel | dir | payload                                              | transfer
//   cfg     | in  | data = props_in_use                                  | valid & ready
//   req     | in  | opcode, prop_index, tick                             | valid & ready
//   rsp     | out | changed_index, found, match_count, index_error, last | valid & ready
//
// Stamp and unused opcodes are answered directly from idle. Init: one RAM write
// per entry. Query: one RAM read per entry.
// Reset: table reads as zero at once via per-entry valid flops; props_in_use = 64.
// A stalled rsp holds the query scan only when a second match needs the output.
module change_tick_table_unit (
  input  logic          clk,
  input  logic          rst,
  ctt_cfg_if.sink       cfg,
  ctt_req_if.sink       req,
  ctt_rsp_if.source     rsp
);
  import ctt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;
  localparam logic [1:0] S_INIT  = 2'd3;

  logic [1:0]              state;
  logic [CNT_W-1:0]        props;
  logic [CNT_W-1:0]        used;
  logic [MAX_PROPS-1:0]    vld;
  logic [CNT_W-1:0]        ptr;
  logic signed [TICK_W-1:0] thr;
  logic                    cmp_vld;
  logic [IDX_W-1:0]        cmp_idx;
  logic                    pend_vld;
  logic [IDX_W-1:0]        pend_idx;
  logic [CNT_W-1:0]        pend_cnt;
  logic [CNT_W-1:0]        match_n;

  logic                    out_free;
  logic                    req_fire;
  logic                    in_range;
  logic [TICK_W-1:0]       rdata;
  logic signed [TICK_W-1:0] cmp_tick;
  logic                    hit;
  logic                    stall;
  logic                    issue;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [TICK_W-1:0]       ram_wdata;
  logic                    out_ld;
  rsp_t                    out_next;

  assign used     = (props > CNT_W'(MAX_PROPS)) ? CNT_W'(MAX_PROPS) : props;
  assign cfg.ready = 1'b1;
  assign out_free = !rsp.valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign req_fire = req.valid && req.ready;
  assign in_range = {1'b0, req.prop_index} < used;

  assign cmp_tick = vld[cmp_idx] ? $signed(rdata) : '0;
  assign hit      = cmp_vld && (cmp_tick > thr);
  assign stall    = hit && pend_vld && !out_free;
  assign issue    = (state == S_SCAN) && !stall && (ptr < used);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = req.prop_index;
    ram_wdata = req.tick;
    if (state == S_INIT) begin
      ram_we    = ptr < used;
      ram_waddr = ptr[IDX_W-1:0];
      ram_wdata = thr;
    end else if (req_fire && req.opcode == OP_STAMP && in_range) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    out_ld   = 1'b0;
    out_next = '0;
    out_next.last = 1'b1;
    case (state)
      S_IDLE: begin
        if (req_fire && req.opcode != OP_QUERY && req.opcode != OP_INIT) begin
          out_ld = 1'b1;
          out_next.index_error = (req.opcode == OP_STAMP) && !in_range;
        end
      end
      S_SCAN: begin
        if (hit && pend_vld && out_free) begin
          out_ld                 = 1'b1;
          out_next.changed_index = pend_idx;
          out_next.found         = 1'b1;
          out_next.match_count   = pend_cnt;
          out_next.last          = 1'b0;
        end
      end
      S_FLUSH: begin
        if (out_free) begin
          out_ld = 1'b1;
          if (pend_vld) begin
            out_next.changed_index = pend_idx;
            out_next.found         = 1'b1;
            out_next.match_count   = pend_cnt;
          end
        end
      end
      S_INIT: begin
        out_ld = (ptr >= used) && out_free;
      end
      default: begin
        out_ld = 1'b0;
      end
    endcase
  end

  ctt_ram #(
    .WIDTH (TICK_W),
    .DEPTH (MAX_PROPS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (ptr[IDX_W-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      props     <= CNT_W'(MAX_PROPS);
      vld       <= '0;
      cmp_vld   <= 1'b0;
      pend_vld  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        props <= cfg.data;
      end
      if (out_ld) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            case (req.opcode)
              OP_STAMP: begin
                if (in_range) begin
                  vld[req.prop_index] <= 1'b1;
                end
              end
              OP_QUERY: begin
                ptr      <= '0;
                thr      <= req.tick;
                cmp_vld  <= 1'b0;
                pend_vld <= 1'b0;
                match_n  <= '0;
                state    <= S_SCAN;
              end
              OP_INIT: begin
                ptr   <= '0;
                thr   <= req.tick;
                state <= S_INIT;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (!stall) begin
            if (hit) begin
              pend_vld <= 1'b1;
              pend_idx <= cmp_idx;
              pend_cnt <= match_n + CNT_W'(1);
              match_n  <= match_n + CNT_W'(1);
            end
            if (issue) begin
              ptr     <= ptr + CNT_W'(1);
              cmp_vld <= 1'b1;
              cmp_idx <= ptr[IDX_W-1:0];
            end else begin
              cmp_vld <= 1'b0;
              state   <= S_FLUSH;
            end
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            pend_vld <= 1'b0;
            state    <= S_IDLE;
          end
        end
        S_INIT: begin
          if (ptr < used) begin
            vld[ptr[IDX_W-1:0]] <= 1'b1;
            ptr <= ptr + CNT_W'(1);
          end else if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      rsp.changed_index <= out_next.changed_index;
      rsp.found         <= out_next.found;
      rsp.match_count   <= out_next.match_count;
      rsp.index_error   <= out_next.index_error;
      rsp.last          <= out_next.last;
    end
  end

endmodule
